// File: src/gss_pkg.sv
`timescale 1ns / 1ps
// gss_pkg: shared types and constants of the gray-scott grid stepper
// no dependencies; used by every module under src

package gss_pkg;

	// default grid shape
	localparam int GRID_ROWS_DEF = 128;
	localparam int GRID_COLS_DEF = 128;

	// field and register widths
	localparam int CONC_W  = 16;
	localparam int COEF_W  = 17;
	localparam int COORD_W = 7;
	localparam int KIND_W  = 2;
	localparam int CIDX_W  = 2;
	localparam int WORD_W  = 2 * CONC_W;

	// one in q1.15
	localparam logic [CONC_W-1:0] ONE_Q15 = 16'd32768;

	// stencil weights in units of 2^-16
	localparam logic [31:0] W_EDGE   = 32'd13107;
	localparam logic [31:0] W_CORNER = 32'd3277;

	// drain wait after the last scan read, covering the last next-grid write, with margin
	localparam int          DRAIN_W      = 4;
	localparam logic [3:0]  DRAIN_CYCLES = 4'd12;

	// request and acknowledge kinds
	localparam logic [KIND_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] REQ_READ  = 2'd1;
	localparam logic [KIND_W-1:0] REQ_GEN   = 2'd2;
	localparam logic [KIND_W-1:0] REQ_BAD   = 2'd3;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_DIFF_A = 2'd0;
	localparam logic [CIDX_W-1:0] REG_DIFF_B = 2'd1;
	localparam logic [CIDX_W-1:0] REG_FEED   = 2'd2;
	localparam logic [CIDX_W-1:0] REG_KILL   = 2'd3;

	// register reset values
	localparam logic [COEF_W-1:0] DIFF_A_RST = 17'd65536;
	localparam logic [COEF_W-1:0] DIFF_B_RST = 17'd32768;
	localparam logic [COEF_W-1:0] FEED_RST   = 17'd1180;
	localparam logic [COEF_W-1:0] KILL_RST   = 17'd3342;

	// row of the 3x3 window a scan read belongs to
	localparam logic [1:0] K_UP   = 2'd0;
	localparam logic [1:0] K_MID  = 2'd1;
	localparam logic [1:0] K_DOWN = 2'd2;

	// coefficient set handed to the arithmetic pipeline
	typedef struct packed {
		logic [COEF_W-1:0] diff_a;
		logic [COEF_W-1:0] diff_b;
		logic [COEF_W-1:0] feed;
		logic [COEF_W-1:0] kill;
	} coef_t;

	// tag travelling with each scan read, aligned with the read data
	typedef struct packed {
		logic       valid;
		logic [1:0] k;
		logic       emit;
	} scan_tag_t;

endpackage

// File: src/gss_bank.sv
`timescale 1ns / 1ps
// gss_bank: one grid buffer, one write and one registered read port
// depends on gss_pkg for the word width

module gss_bank #(
	parameter int DEPTH = gss_pkg::GRID_ROWS_DEF * gss_pkg::GRID_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [gss_pkg::WORD_W-1:0]  wr_data,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [gss_pkg::WORD_W-1:0]  rd_data
);

	logic [gss_pkg::WORD_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: src/gss_scan.sv
`timescale 1ns / 1ps
// gss_scan: address sequencer for one generation over the current buffer
// depends on gss_pkg for the scan tag type

module gss_scan #(
	parameter int GRID_ROWS = gss_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = gss_pkg::GRID_COLS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   done,
	output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0] rd_addr,
	output gss_pkg::scan_tag_t                     tag_s1,
	output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0] cell_addr_s1
);

	localparam int AW = $clog2(GRID_ROWS * GRID_COLS);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int JW = $clog2(GRID_COLS + 2);

	logic          run_q;
	logic [RW-1:0] r_q;
	logic [JW-1:0] j_q;
	logic [1:0]    k_q;
	logic [31:0]   rsel;
	logic [31:0]   csel;
	logic [31:0]   ccell;
	logic          emit;
	logic          last_k;
	logic          last_j;
	logic          last_r;

	// wrapped row and column of the current read
	always_comb begin
		case (k_q)
			gss_pkg::K_UP:   rsel = (r_q == '0) ? 32'(GRID_ROWS - 1) : 32'(r_q) - 32'd1;
			gss_pkg::K_MID:  rsel = 32'(r_q);
			default:         rsel = (32'(r_q) == 32'(GRID_ROWS - 1)) ? 32'd0
			                        : 32'(r_q) + 32'd1;
		endcase
		if (j_q == '0) begin
			csel = 32'(GRID_COLS - 1);
		end else if (32'(j_q) == 32'(GRID_COLS + 1)) begin
			csel = 32'd0;
		end else begin
			csel = 32'(j_q) - 32'd1;
		end
		ccell  = 32'(j_q) - 32'd2;
		last_k = (k_q == gss_pkg::K_DOWN);
		last_j = (32'(j_q) == 32'(GRID_COLS + 1));
		last_r = (32'(r_q) == 32'(GRID_ROWS - 1));
		emit   = last_k && (32'(j_q) >= 32'd2);
	end

	assign rd_addr = AW'(rsel * 32'(GRID_COLS) + csel);

	// counters: k innermost, then window column, then row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			r_q   <= '0;
			j_q   <= '0;
			k_q   <= gss_pkg::K_UP;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				r_q   <= '0;
				j_q   <= '0;
				k_q   <= gss_pkg::K_UP;
			end else if (run_q) begin
				if (!last_k) begin
					k_q <= k_q + 2'd1;
				end else begin
					k_q <= gss_pkg::K_UP;
					if (!last_j) begin
						j_q <= j_q + 1'b1;
					end else begin
						j_q <= '0;
						if (last_r) begin
							run_q <= 1'b0;
							done  <= 1'b1;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end
				end
			end
		end
	end

	// tag aligned with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= run_q;
			tag_s1.k     <= k_q;
			tag_s1.emit  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		cell_addr_s1 <= AW'(32'(r_q) * 32'(GRID_COLS) + ccell);
	end

endmodule

// File: src/gss_calc.sv
`timescale 1ns / 1ps
// gss_calc: 3x3 window and reaction-diffusion arithmetic pipeline
// depends on gss_pkg for coefficients, tags and constants

module gss_calc #(
	parameter int AW = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gss_pkg::coef_t              coef,
	input  gss_pkg::scan_tag_t          tag_s1,
	input  logic [AW-1:0]               cell_addr_s1,
	input  logic [gss_pkg::WORD_W-1:0]  rd_data,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [gss_pkg::WORD_W-1:0]  wr_data
);

	localparam int CW = gss_pkg::CONC_W;

	// column staging and window, indexed [column][row]
	logic [CW-1:0] up_a_q, up_b_q, mid_a_q, mid_b_q;
	logic [CW-1:0] wa_q [3][3];
	logic [CW-1:0] wb_q [3][3];
	logic          win_v_q;
	logic [AW-1:0] win_addr_q;

	// stage registers
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0]        ad_s1, ad_s2, ad_s3, ad_s4;
	logic [17:0]          ea_s1, eb_s1, ca_s1, cb_s1;
	logic [CW-1:0]        a_s1, b_s1, a_s2, b_s2, a_s3, b_s3;
	logic signed [33:0]   la_s2, lb_s2;
	logic [31:0]          ab_s2;
	logic [32:0]          fa_s2, fa_s3;
	logic [33:0]          kfb_s2, kfb_s3;
	logic signed [51:0]   dla_s3, dlb_s3;
	logic [47:0]          abb_s3;
	logic signed [53:0]   na_s4, nb_s4;

	logic [31:0] pos_a, pos_b;

	// clamp a 2^-47 value to q1.15, rounding half up
	function automatic logic [CW-1:0] settle(input logic signed [53:0] v);
		logic [53:0] s;
		logic [21:0] q;
		s = 54'(v) + 54'd2147483648;
		q = s[53:32];
		if (v <= 0) begin
			settle = '0;
		end else if (q > 22'(gss_pkg::ONE_Q15)) begin
			settle = gss_pkg::ONE_Q15;
		end else begin
			settle = q[CW-1:0];
		end
	endfunction

	// window fill: stage the up and mid reads, shift on the down read
	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			case (tag_s1.k)
				gss_pkg::K_UP: begin
					up_a_q <= rd_data[CW-1:0];
					up_b_q <= rd_data[2*CW-1:CW];
				end
				gss_pkg::K_MID: begin
					mid_a_q <= rd_data[CW-1:0];
					mid_b_q <= rd_data[2*CW-1:CW];
				end
				default: begin
					wa_q[0] <= wa_q[1];
					wa_q[1] <= wa_q[2];
					wb_q[0] <= wb_q[1];
					wb_q[1] <= wb_q[2];
					wa_q[2][0] <= up_a_q;
					wa_q[2][1] <= mid_a_q;
					wa_q[2][2] <= rd_data[CW-1:0];
					wb_q[2][0] <= up_b_q;
					wb_q[2][1] <= mid_b_q;
					wb_q[2][2] <= rd_data[2*CW-1:CW];
				end
			endcase
		end
		win_addr_q <= cell_addr_s1;
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_v_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			wr_en   <= 1'b0;
		end else begin
			win_v_q <= tag_s1.valid && (tag_s1.k == gss_pkg::K_DOWN) && tag_s1.emit;
			v_s1    <= win_v_q;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			wr_en   <= v_s4;
		end
	end

	// s1: neighbour sums
	always_ff @(posedge clk) begin
		ea_s1 <= 18'(wa_q[0][1]) + 18'(wa_q[2][1]) + 18'(wa_q[1][0]) + 18'(wa_q[1][2]);
		eb_s1 <= 18'(wb_q[0][1]) + 18'(wb_q[2][1]) + 18'(wb_q[1][0]) + 18'(wb_q[1][2]);
		ca_s1 <= 18'(wa_q[0][0]) + 18'(wa_q[0][2]) + 18'(wa_q[2][0]) + 18'(wa_q[2][2]);
		cb_s1 <= 18'(wb_q[0][0]) + 18'(wb_q[0][2]) + 18'(wb_q[2][0]) + 18'(wb_q[2][2]);
		a_s1  <= wa_q[1][1];
		b_s1  <= wb_q[1][1];
		ad_s1 <= win_addr_q;
	end

	assign pos_a = 32'(ea_s1) * gss_pkg::W_EDGE + 32'(ca_s1) * gss_pkg::W_CORNER;
	assign pos_b = 32'(eb_s1) * gss_pkg::W_EDGE + 32'(cb_s1) * gss_pkg::W_CORNER;

	// s2: laplacians, a*b and the feed and kill products
	always_ff @(posedge clk) begin
		la_s2  <= $signed({2'b00, pos_a}) - $signed({2'b00, a_s1, 16'h0000});
		lb_s2  <= $signed({2'b00, pos_b}) - $signed({2'b00, b_s1, 16'h0000});
		ab_s2  <= 32'(a_s1) * 32'(b_s1);
		fa_s2  <= 33'(coef.feed) * 33'(gss_pkg::ONE_Q15 - a_s1);
		kfb_s2 <= (34'(coef.kill) + 34'(coef.feed)) * 34'(b_s1);
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		ad_s2  <= ad_s1;
	end

	// s3: diffusion terms and a*b*b
	always_ff @(posedge clk) begin
		dla_s3 <= $signed({1'b0, coef.diff_a}) * la_s2;
		dlb_s3 <= $signed({1'b0, coef.diff_b}) * lb_s2;
		abb_s3 <= 48'(ab_s2) * 48'(b_s2);
		fa_s3  <= fa_s2;
		kfb_s3 <= kfb_s2;
		a_s3   <= a_s2;
		b_s3   <= b_s2;
		ad_s3  <= ad_s2;
	end

	// s4: sum every term in units of 2^-47
	always_ff @(posedge clk) begin
		na_s4 <= $signed({6'd0, a_s3, 32'd0}) + 54'(dla_s3)
		       - $signed({4'd0, abb_s3, 2'd0}) + $signed({5'd0, fa_s3, 16'd0});
		nb_s4 <= $signed({6'd0, b_s3, 32'd0}) + 54'(dlb_s3)
		       + $signed({4'd0, abb_s3, 2'd0}) - $signed({4'd0, kfb_s3, 16'd0});
		ad_s4 <= ad_s3;
	end

	// s5: clamp and hand to the next buffer
	always_ff @(posedge clk) begin
		wr_data <= {settle(nb_s4), settle(na_s4)};
		wr_addr <= ad_s4;
	end

endmodule

// File: src/gray_scott_grid_step.sv
`timescale 1ns / 1ps
// gray_scott_grid_step: top level, request decode, buffers and result register
// depends on gss_pkg, gss_bank, gss_scan and gss_calc
//
// Usage
//   s_axis carries requests: tuser is the request kind (write cell, read cell,
//   run one generation), tdata the cell coordinates and values to write.
//   m_axis returns exactly one item per request: tuser echoes the kind,
//   tdata holds the read concentrations (zero for anything but a read).
//   cfg_we/cfg_idx/cfg_wdata write the diffusion, feed and kill registers;
//   write them only while no request is in flight.
// Request handling
//   write, unknown kind or cell outside the grid: result registered in the
//   cycle after acceptance; read: via the memory read and the read state.
//   generation: paced by the single read port of the current buffer, three
//   reads per window column along a sliding 3x3 window; results go to the
//   other buffer, which then becomes current.
//   One request is worked on at a time.
// Reset clears the registers to their defaults and the control state; the
//   grid contents are undefined until written. When m_axis stalls the result
//   stays in its register and a new request is taken at the edge it leaves.

module gray_scott_grid_step #(
	parameter int GRID_ROWS = gss_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = gss_pkg::GRID_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// cell_row[6:0], cell_col[13:7], write_a[29:14], write_b[45:30], zero fill
	input  logic [47:0]                 s_axis_tdata,
	// req_type[1:0]
	input  logic [gss_pkg::KIND_W-1:0]  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// read_a[15:0], read_b[31:16]
	output logic [31:0]                 m_axis_tdata,
	// ack_kind[1:0]
	output logic [gss_pkg::KIND_W-1:0]  m_axis_tuser,
	input  logic                        cfg_we,
	input  logic [gss_pkg::CIDX_W-1:0]  cfg_idx,
	input  logic [gss_pkg::COEF_W-1:0]  cfg_wdata
);

	localparam int AW = $clog2(GRID_ROWS * GRID_COLS);
	localparam int CW = gss_pkg::CONC_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_GEN   = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t                      state_q;
	logic                        cur_q;
	logic [gss_pkg::DRAIN_W-1:0] drain_q;
	gss_pkg::coef_t              coef_q;

	logic                        accept;
	logic [gss_pkg::COORD_W-1:0] row, col;
	logic [CW-1:0]               wa, wb, wa_sat, wb_sat;
	logic                        in_grid;
	logic [AW-1:0]               req_addr;
	logic                        cell_wr;

	logic                        scan_start, scan_done;
	logic [AW-1:0]               scan_addr, cell_addr_s1;
	gss_pkg::scan_tag_t          tag_s1;
	logic                        calc_wr;
	logic [AW-1:0]               calc_addr;
	logic [gss_pkg::WORD_W-1:0]  calc_data;

	logic [AW-1:0]               rd_addr;
	logic [gss_pkg::WORD_W-1:0]  rd0, rd1, rd_cur;
	logic                        we0, we1;
	logic [AW-1:0]               wad0, wad1;
	logic [gss_pkg::WORD_W-1:0]  wd0, wd1;

	logic                        out_load;
	logic [31:0]                 out_data;
	logic [gss_pkg::KIND_W-1:0]  out_kind;

	// request decode
	assign row    = s_axis_tdata[6:0];
	assign col    = s_axis_tdata[13:7];
	assign wa     = s_axis_tdata[29:14];
	assign wb     = s_axis_tdata[45:30];
	assign wa_sat = (wa > gss_pkg::ONE_Q15) ? gss_pkg::ONE_Q15 : wa;
	assign wb_sat = (wb > gss_pkg::ONE_Q15) ? gss_pkg::ONE_Q15 : wb;
	assign in_grid = (32'(row) < 32'(GRID_ROWS)) && (32'(col) < 32'(GRID_COLS));
	assign req_addr = AW'(32'(row) * 32'(GRID_COLS) + 32'(col));

	assign s_axis_tready = (state_q == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cell_wr       = accept && (s_axis_tuser == gss_pkg::REQ_WRITE) && in_grid;
	assign scan_start    = accept && (s_axis_tuser == gss_pkg::REQ_GEN);

	// buffer ports: the current one is read and takes cell writes,
	// the other one takes the new generation
	assign rd_addr = (state_q == ST_GEN) ? scan_addr : req_addr;
	assign rd_cur  = cur_q ? rd1 : rd0;
	assign we0  = cur_q ? calc_wr : cell_wr;
	assign we1  = cur_q ? cell_wr : calc_wr;
	assign wad0 = cur_q ? calc_addr : req_addr;
	assign wad1 = cur_q ? req_addr : calc_addr;
	assign wd0  = cur_q ? calc_data : {wb_sat, wa_sat};
	assign wd1  = cur_q ? {wb_sat, wa_sat} : calc_data;

	gss_bank #(.DEPTH(GRID_ROWS * GRID_COLS)) u_bank0 (
		.clk     (clk),
		.wr_en   (we0),
		.wr_addr (wad0),
		.wr_data (wd0),
		.rd_addr (rd_addr),
		.rd_data (rd0)
	);

	gss_bank #(.DEPTH(GRID_ROWS * GRID_COLS)) u_bank1 (
		.clk     (clk),
		.wr_en   (we1),
		.wr_addr (wad1),
		.wr_data (wd1),
		.rd_addr (rd_addr),
		.rd_data (rd1)
	);

	gss_scan #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (scan_start),
		.done         (scan_done),
		.rd_addr      (scan_addr),
		.tag_s1       (tag_s1),
		.cell_addr_s1 (cell_addr_s1)
	);

	gss_calc #(.AW(AW)) u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.coef         (coef_q),
		.tag_s1       (tag_s1),
		.cell_addr_s1 (cell_addr_s1),
		.rd_data      (rd_cur),
		.wr_en        (calc_wr),
		.wr_addr      (calc_addr),
		.wr_data      (calc_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.diff_a <= gss_pkg::DIFF_A_RST;
			coef_q.diff_b <= gss_pkg::DIFF_B_RST;
			coef_q.feed   <= gss_pkg::FEED_RST;
			coef_q.kill   <= gss_pkg::KILL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				gss_pkg::REG_DIFF_A: coef_q.diff_a <= cfg_wdata;
				gss_pkg::REG_DIFF_B: coef_q.diff_b <= cfg_wdata;
				gss_pkg::REG_FEED:   coef_q.feed   <= cfg_wdata;
				gss_pkg::REG_KILL:   coef_q.kill   <= cfg_wdata;
				default:             coef_q.kill   <= cfg_wdata;
			endcase
		end
	end

	// result selection
	always_comb begin
		out_load = 1'b0;
		out_data = '0;
		out_kind = s_axis_tuser;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_axis_tuser)
						gss_pkg::REQ_READ: out_load = !in_grid;
						gss_pkg::REQ_GEN:  out_load = 1'b0;
						default:           out_load = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				out_load = 1'b1;
				out_data = rd_cur;
				out_kind = gss_pkg::REQ_READ;
			end
			ST_DRAIN: begin
				out_load = (drain_q == '0);
				out_kind = gss_pkg::REQ_GEN;
			end
			default: out_load = 1'b0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= 1'b0;
			drain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (s_axis_tuser == gss_pkg::REQ_READ) && in_grid) begin
						state_q <= ST_READ;
					end else if (scan_start) begin
						state_q <= ST_GEN;
					end
				end
				ST_READ: state_q <= ST_IDLE;
				ST_GEN: begin
					if (scan_done) begin
						state_q <= ST_DRAIN;
						drain_q <= gss_pkg::DRAIN_CYCLES;
					end
				end
				ST_DRAIN: begin
					if (drain_q == '0) begin
						state_q <= ST_IDLE;
						cur_q   <= !cur_q;
					end else begin
						drain_q <= drain_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= out_data;
			m_axis_tuser <= out_kind;
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for gray_scott_grid_step, with its own grid model
// depends on gss_pkg and the gray_scott_grid_step rtl
// directed cell accesses, a full grid fill, then random phases with generations

module tb_top;

	localparam int ROWS  = 128;
	localparam int COLS  = 128;
	localparam int CELLS = ROWS * COLS;
	localparam int LIMIT = 4000000;

	typedef struct {
		logic [gss_pkg::KIND_W-1:0] kind;
		logic [15:0]                conc_a;
		logic [15:0]                conc_b;
	} ack_t;

	typedef struct {
		logic [gss_pkg::KIND_W-1:0] kind;
		int                         row;
		int                         col;
		logic [15:0]                wa;
		logic [15:0]                wb;
		bit                         typed;
		logic [15:0]                ea;
		logic [15:0]                eb;
	} req_row_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [gss_pkg::KIND_W-1:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [gss_pkg::KIND_W-1:0] m_axis_tuser;
	logic cfg_we;
	logic [gss_pkg::CIDX_W-1:0] cfg_idx;
	logic [gss_pkg::COEF_W-1:0] cfg_wdata;

	// model state
	logic [31:0] grid_conc [0:CELLS-1];
	logic [31:0] grid_next [0:CELLS-1];
	logic [gss_pkg::COEF_W-1:0] diff_a, diff_b, feed, kill;
	ack_t pending_acks[$];

	int  mismatches = 0;
	int  cycles = 0;
	bit  idle_on = 1;
	bit  hold_req = 0;

	gray_scott_grid_step u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("gray_scott_grid_step: mismatch");
			$finish;
		end
	end

	// one species of a cell, sh selects a or b
	function automatic longint conc_of(int r, int c, int sh);
		return longint'((grid_conc[r * COLS + c] >> sh) & 32'hFFFF);
	endfunction

	// 3x3 wrapped laplacian in units of 2^-31
	function automatic longint stencil(int r, int c, int sh);
		int ru, rd, cl, cr;
		longint edges, corners;
		ru = (r == 0) ? ROWS - 1 : r - 1;
		rd = (r == ROWS - 1) ? 0 : r + 1;
		cl = (c == 0) ? COLS - 1 : c - 1;
		cr = (c == COLS - 1) ? 0 : c + 1;
		edges = conc_of(r, cl, sh) + conc_of(r, cr, sh) + conc_of(ru, c, sh)
			+ conc_of(rd, c, sh);
		corners = conc_of(ru, cl, sh) + conc_of(ru, cr, sh) + conc_of(rd, cl, sh)
			+ conc_of(rd, cr, sh);
		return -64'sd65536 * conc_of(r, c, sh) + longint'(gss_pkg::W_EDGE) * edges
			+ longint'(gss_pkg::W_CORNER) * corners;
	endfunction

	// clamp a 2^-47 sum to q1.15 with round half up
	function automatic logic [15:0] clamp_q15(longint v);
		longint q;
		if (v <= 0)
			return 16'd0;
		q = (v + 64'sd2147483648) >>> 32;
		return (q > 32768) ? gss_pkg::ONE_Q15 : q[15:0];
	endfunction

	// advance the model grid by one generation
	function automatic void evolve_grid();
		longint a, b, abb4, na, nb;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				a = conc_of(r, c, 0);
				b = conc_of(r, c, 16);
				abb4 = a * b * b * 4;
				na = a * 64'sd4294967296 + longint'(diff_a) * stencil(r, c, 0) - abb4
					+ longint'(feed) * (32768 - a) * 65536;
				nb = b * 64'sd4294967296 + longint'(diff_b) * stencil(r, c, 16) + abb4
					- (longint'(kill) + longint'(feed)) * b * 65536;
				grid_next[r * COLS + c] = {clamp_q15(nb), clamp_q15(na)};
			end
		end
		for (int i = 0; i < CELLS; i++)
			grid_conc[i] = grid_next[i];
	endfunction

	// work out the acknowledge of one accepted request
	function automatic ack_t predict_ack(logic [gss_pkg::KIND_W-1:0] kind, int row, int col,
			logic [15:0] wa, logic [15:0] wb);
		ack_t ack;
		ack.kind = kind;
		ack.conc_a = 0;
		ack.conc_b = 0;
		case (kind)
			gss_pkg::REQ_WRITE: begin
				if (wa > gss_pkg::ONE_Q15) wa = gss_pkg::ONE_Q15;
				if (wb > gss_pkg::ONE_Q15) wb = gss_pkg::ONE_Q15;
				grid_conc[row * COLS + col] = {wb, wa};
			end
			gss_pkg::REQ_READ: begin
				ack.conc_a = grid_conc[row * COLS + col][15:0];
				ack.conc_b = grid_conc[row * COLS + col][31:16];
			end
			gss_pkg::REQ_GEN: evolve_grid();
			default: ;
		endcase
		return ack;
	endfunction

	// offer one request, wait for it to be taken, record what must come back
	task automatic send_req(req_row_t rq);
		ack_t ack;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= rq.kind;
		s_axis_tdata <= {2'b00, rq.wb, rq.wa, 7'(rq.col), 7'(rq.row)};
		do @(posedge clk); while (!s_axis_tready);
		ack = predict_ack(rq.kind, rq.row, rq.col, rq.wa, rq.wb);
		if (rq.typed) begin
			ack.conc_a = rq.ea;
			ack.conc_b = rq.eb;
		end
		pending_acks.push_back(ack);
	endtask

	function automatic req_row_t mk_req(logic [gss_pkg::KIND_W-1:0] kind, int row, int col,
			logic [15:0] wa, logic [15:0] wb);
		req_row_t rq;
		rq.kind = kind; rq.row = row; rq.col = col; rq.wa = wa; rq.wb = wb;
		rq.typed = 0; rq.ea = 0; rq.eb = 0;
		return rq;
	endfunction

	function automatic req_row_t mk_typed(logic [gss_pkg::KIND_W-1:0] kind, int row,
			int col, logic [15:0] wa, logic [15:0] wb, logic [15:0] ea, logic [15:0] eb);
		req_row_t rq;
		rq = mk_req(kind, row, col, wa, wb);
		rq.typed = 1; rq.ea = ea; rq.eb = eb;
		return rq;
	endfunction

	// wait until every acknowledge is in, then settle
	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending_acks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_coef(logic [gss_pkg::CIDX_W-1:0] idx,
			logic [gss_pkg::COEF_W-1:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			gss_pkg::REG_DIFF_A: diff_a = val;
			gss_pkg::REG_DIFF_B: diff_b = val;
			gss_pkg::REG_FEED:   feed = val;
			default:             kill = val;
		endcase
	endtask

	task automatic set_coefs(logic [gss_pkg::COEF_W-1:0] da, logic [gss_pkg::COEF_W-1:0] db,
			logic [gss_pkg::COEF_W-1:0] f, logic [gss_pkg::COEF_W-1:0] k);
		write_coef(gss_pkg::REG_DIFF_A, da);
		write_coef(gss_pkg::REG_DIFF_B, db);
		write_coef(gss_pkg::REG_FEED, f);
		write_coef(gss_pkg::REG_KILL, k);
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_conc();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return gss_pkg::ONE_Q15;
			2: return 16'd0;
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready = 0;
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// compare each returned item with the oldest expectation
	always @(posedge clk) begin
		ack_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_acks.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result kind %0d data %h", m_axis_tuser,
						m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_acks.pop_front();
				if (m_axis_tuser !== want.kind || m_axis_tdata[15:0] !== want.conc_a
						|| m_axis_tdata[31:16] !== want.conc_b) begin
					if (mismatches < 10)
						$display("result: want kind %0d a %0d b %0d, got kind %0d a %0d b %0d",
							want.kind, want.conc_a, want.conc_b, m_axis_tuser,
							m_axis_tdata[15:0], m_axis_tdata[31:16]);
					mismatches++;
				end
			end
		end
	end

	// main sequence
	initial begin
		req_row_t directed [$];
		req_row_t rq;
		logic [gss_pkg::KIND_W-1:0] kind;
		int gen_slot, idx;

		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = gss_pkg::REQ_WRITE;
		cfg_we = 0;
		cfg_idx = gss_pkg::REG_DIFF_A;
		cfg_wdata = 0;
		diff_a = gss_pkg::DIFF_A_RST;
		diff_b = gss_pkg::DIFF_B_RST;
		feed = gss_pkg::FEED_RST;
		kill = gss_pkg::KILL_RST;
		for (int i = 0; i < CELLS; i++)
			grid_conc[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: corners, saturation on write, unknown request kind
		directed.push_back(mk_typed(gss_pkg::REQ_WRITE, 0, 0, gss_pkg::ONE_Q15, 16'd0,
			16'd0, 16'd0));
		directed.push_back(mk_typed(gss_pkg::REQ_READ, 0, 0, 16'hFFFF, 16'hFFFF,
			gss_pkg::ONE_Q15, 16'd0));
		directed.push_back(mk_typed(gss_pkg::REQ_WRITE, 127, 127, 16'hFFFF, 16'hFFFF, 0, 0));
		directed.push_back(mk_typed(gss_pkg::REQ_READ, 127, 127, 0, 0, gss_pkg::ONE_Q15,
			gss_pkg::ONE_Q15));
		directed.push_back(mk_typed(gss_pkg::REQ_WRITE, 0, 127, 16'd32769, 16'd1, 0, 0));
		directed.push_back(mk_typed(gss_pkg::REQ_READ, 0, 127, 0, 0, gss_pkg::ONE_Q15,
			16'd1));
		directed.push_back(mk_typed(gss_pkg::REQ_WRITE, 127, 0, 16'd0, gss_pkg::ONE_Q15,
			0, 0));
		directed.push_back(mk_typed(gss_pkg::REQ_READ, 127, 0, 0, 0, 16'd0,
			gss_pkg::ONE_Q15));
		directed.push_back(mk_typed(gss_pkg::REQ_BAD, 127, 127, 16'hFFFF, 16'hFFFF, 0, 0));
		directed.push_back(mk_typed(gss_pkg::REQ_BAD, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(gss_pkg::REQ_WRITE, 42, 85, 16'h5555, 16'h2AAA));
		directed.push_back(mk_req(gss_pkg::REQ_READ, 42, 85, 0, 0));
		directed.push_back(mk_req(gss_pkg::REQ_WRITE, 85, 42, 16'h7FFF, 16'h8000));
		directed.push_back(mk_req(gss_pkg::REQ_READ, 85, 42, 16'h1234, 16'h4321));
		directed.push_back(mk_typed(gss_pkg::REQ_READ, 0, 0, 0, 0, gss_pkg::ONE_Q15, 16'd0));
		foreach (directed[i])
			send_req(directed[i]);

		// fill the whole grid so generations only see written cells
		hold_req = 1;
		for (int i = 0; i < CELLS; i++)
			send_req(mk_req(gss_pkg::REQ_WRITE, i / COLS, i % COLS, rand_conc(),
				rand_conc()));
		// first generation on reset coefficients
		send_req(mk_req(gss_pkg::REQ_GEN, 0, 0, 0, 0));
		send_req(mk_req(gss_pkg::REQ_READ, 64, 64, 0, 0));

		// random phases over several coefficient settings
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: set_coefs(17'd0, 17'd0, 17'd0, 17'd0);
				1: set_coefs(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
				2: set_coefs(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
				3: set_coefs(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
					17'($urandom_range(0, 4000)), 17'($urandom_range(0, 8000)));
				default: begin
					set_coefs(gss_pkg::DIFF_A_RST, gss_pkg::DIFF_B_RST, gss_pkg::FEED_RST,
						gss_pkg::KILL_RST);
					idle_on = 0;
				end
			endcase
			gen_slot = $urandom_range(0, 19);
			for (int n = 0; n < 20; n++) begin
				if (n == gen_slot) begin
					kind = gss_pkg::REQ_GEN;
				end else begin
					idx = $urandom_range(0, 9);
					kind = (idx < 4) ? gss_pkg::REQ_WRITE
						: (idx < 8) ? gss_pkg::REQ_READ : gss_pkg::REQ_BAD;
				end
				rq = mk_req(kind, $urandom_range(0, 127), $urandom_range(0, 127),
					rand_conc(), rand_conc());
				send_req(rq);
			end
		end

		drain();
		if (mismatches == 0)
			$display("gray_scott_grid_step: match");
		else
			$display("gray_scott_grid_step: mismatch");
		$finish;
	end

endmodule
